// ===== rtl/bda_pkg.sv =====
`timescale 1ns / 1ps
// Package for the block-average downscaler with ASCII ramp.
// Holds shared widths, reset values, the register map, job and config types
// and the ramp table. No dependencies.
package bda_pkg;

  localparam int MAX_BLOCK_DIM = 64;
  localparam int MAX_SRC_DIM   = 4096;
  localparam int DEF_OUT_COLS  = 64;

  localparam int SRC_W   = 13;
  localparam int DIM_W   = 7;
  localparam int THR_W   = 8;
  localparam int PIX_W   = 8;
  localparam int CODE_W  = 7;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;

  // positions run from 0 to MAX_SRC_DIM-1
  localparam int POS_W   = $clog2(MAX_SRC_DIM);
  // offset inside a tile
  localparam int TOFF_W  = (MAX_BLOCK_DIM > 1) ? $clog2(MAX_BLOCK_DIM) : 1;
  // one bit of headroom over a full tile of white pixels
  localparam int SUM_W   = $clog2(MAX_BLOCK_DIM * MAX_BLOCK_DIM * 255 + 1) + 1;
  localparam int AREA_W  = $clog2(MAX_BLOCK_DIM * MAX_BLOCK_DIM + 1);

  localparam logic [SRC_W-1:0] RST_SRC_DIM  = SRC_W'(720);
  localparam logic [DIM_W-1:0] RST_BLOCK    = DIM_W'(15);
  localparam logic [DIM_W-1:0] RST_OUT_DIM  = DIM_W'(48);
  localparam logic [THR_W-1:0] RST_THR      = THR_W'(128);
  localparam logic [THR_W-1:0] PIX_MAX      = THR_W'(255);
  localparam logic [3:0]       RAMP_TOP     = 4'd10;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_BLOCK_W    = 3'd2,
    REG_BLOCK_H    = 3'd3,
    REG_OUT_COLS   = 3'd4,
    REG_OUT_ROWS   = 3'd5,
    REG_THRESHOLD  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {F_IDLE, F_RECALC, F_ACC} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV1, B_DIV2, B_OUT} back_state_t;

  // clamped configuration
  typedef struct packed {
    logic [SRC_W-1:0] sw;
    logic [SRC_W-1:0] sh;
    logic [DIM_W-1:0] bw;
    logic [DIM_W-1:0] bh;
    logic [DIM_W-1:0] oc;
    logic [DIM_W-1:0] orows;
    logic [THR_W-1:0] thr;
  } cfg_t;

  // completed tile handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             row_end;
    logic             frame_end;
  } job_t;

  function automatic logic [CODE_W-1:0] ramp_code(input logic [3:0] idx);
    logic [CODE_W-1:0] c;
    case (idx)
      4'd0:    c = 7'd32;
      4'd1:    c = 7'd46;
      4'd2:    c = 7'd58;
      4'd3:    c = 7'd45;
      4'd4:    c = 7'd61;
      4'd5:    c = 7'd43;
      4'd6:    c = 7'd42;
      4'd7:    c = 7'd35;
      4'd8:    c = 7'd37;
      4'd9:    c = 7'd56;
      default: c = 7'd64;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bda_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bda_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of completed tiles between front and back.
// Depends on bda_pkg.
module bda_fifo
  import bda_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wdata,
  output logic full,
  input  logic rd,
  output job_t rdata,
  output logic empty
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rptr];

  // store on transfer in
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wptr] <= wdata;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && !empty) rptr <= ~rptr;
      case ({wr && !full, rd && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/bda_front.sv =====
`timescale 1ns / 1ps
// Front part: tracks the raster position, accumulates pixels into per-column
// sums held in bda_ram and hands completed tiles on. Depends on bda_pkg, bda_ram.
module bda_front
  import bda_pkg::*;
#(
  parameter int MAX_OUT_COLS = DEF_OUT_COLS
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             cfg_wr,
  input  logic             push,
  output logic             full,
  input  logic [PIX_W-1:0] pixel,
  input  logic             start_frame,
  output logic             job_wr,
  output job_t             job,
  input  logic             job_full
);

  localparam int AW  = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int CNW = $clog2(POS_W + 1);

  front_state_t state;
  front_state_t state_next;

  logic [POS_W-1:0]  col_pos, row_pos, tc, tr;
  logic [TOFF_W-1:0] tx, ty;
  logic [MAX_OUT_COLS-1:0] valid;
  logic              dirty;

  // latched item
  logic [PIX_W-1:0]  pix;
  logic [AW-1:0]     addr;
  logic              tile_end, rend, fend, wrap;

  // position recompute
  logic [POS_W-1:0]  cnum, rnum;
  logic [DIM_W:0]    crem, rrem;
  logic [CNW-1:0]    rcnt;
  logic [DIM_W:0]    crem_sh, rrem_sh;
  logic              cge, rge;

  // effective position of the accepted pixel
  logic [POS_W-1:0]  c_e, r_e, tc_e, tr_e;
  logic [TOFF_W-1:0] tx_e, ty_e;
  logic              accept, in_tile;
  logic              col_wrap, row_wrap, tx_last, ty_last;

  logic [SUM_W-1:0]  rdata, sum;

  assign accept = push && !full;
  assign full   = (state != F_IDLE) || dirty;

  assign c_e  = start_frame ? '0 : col_pos;
  assign r_e  = start_frame ? '0 : row_pos;
  assign tc_e = start_frame ? '0 : tc;
  assign tr_e = start_frame ? '0 : tr;
  assign tx_e = start_frame ? '0 : tx;
  assign ty_e = start_frame ? '0 : ty;

  assign in_tile  = (tc_e < POS_W'(cfg.oc)) && (tr_e < POS_W'(cfg.orows));
  assign tx_last  = ({1'b0, tx_e} == (TOFF_W + 1)'(cfg.bw - DIM_W'(1)));
  assign ty_last  = ({1'b0, ty_e} == (TOFF_W + 1)'(cfg.bh - DIM_W'(1)));
  assign col_wrap = ({1'b0, c_e} + SRC_W'(1)) >= cfg.sw;
  assign row_wrap = ({1'b0, r_e} + SRC_W'(1)) >= cfg.sh;

  // one restoring step for column and row
  assign crem_sh = {crem[DIM_W-1:0], cnum[POS_W-1]};
  assign rrem_sh = {rrem[DIM_W-1:0], rnum[POS_W-1]};
  assign cge     = crem_sh >= {1'b0, cfg.bw};
  assign rge     = rrem_sh >= {1'b0, cfg.bh};

  bda_ram #(.WIDTH(SUM_W), .DEPTH(MAX_OUT_COLS), .AW(AW)) u_sums (
    .clk   (clk),
    .we    ((state == F_ACC) && !tile_end),
    .waddr (addr),
    .wdata (sum),
    .re    (accept && in_tile),
    .raddr (tc_e[AW-1:0]),
    .rdata (rdata)
  );

  assign sum    = (valid[addr] ? rdata : '0) + SUM_W'(pix);
  assign job_wr = (state == F_ACC) && tile_end && !job_full;
  assign job    = '{sum: sum, row_end: rend, frame_end: fend};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (dirty) state_next = F_RECALC;
        else if (accept && in_tile) state_next = F_ACC;
      end
      F_RECALC: begin
        if (rcnt == CNW'(POS_W - 1)) state_next = F_IDLE;
      end
      F_ACC: begin
        if (!tile_end || !job_full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // positions, valid bits and recompute control
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
      tc      <= '0;
      tr      <= '0;
      tx      <= '0;
      ty      <= '0;
      valid   <= '0;
      dirty   <= 1'b0;
      rcnt    <= '0;
    end else begin
      if (cfg_wr) dirty <= 1'b1;
      case (state)
        F_IDLE: begin
          if (dirty) begin
            if (!cfg_wr) dirty <= 1'b0;
            rcnt <= '0;
          end else if (accept) begin
            // advance the position
            if (col_wrap) begin
              col_pos <= '0;
              tx      <= '0;
              tc      <= '0;
              if (row_wrap) begin
                row_pos <= '0;
                ty      <= '0;
                tr      <= '0;
              end else begin
                row_pos <= r_e + POS_W'(1);
                if (ty_last) begin
                  ty <= '0;
                  tr <= tr_e + POS_W'(1);
                end else begin
                  ty <= ty_e + TOFF_W'(1);
                  tr <= tr_e;
                end
              end
            end else begin
              col_pos <= c_e + POS_W'(1);
              row_pos <= r_e;
              ty      <= ty_e;
              tr      <= tr_e;
              if (tx_last) begin
                tx <= '0;
                tc <= tc_e + POS_W'(1);
              end else begin
                tx <= tx_e + TOFF_W'(1);
                tc <= tc_e;
              end
            end
            if (start_frame || (col_wrap && row_wrap && !in_tile)) valid <= '0;
          end
        end
        F_RECALC: begin
          rcnt <= rcnt + CNW'(1);
          if (rcnt == CNW'(POS_W - 1)) begin
            tc <= {cnum[POS_W-2:0], cge};
            tr <= {rnum[POS_W-2:0], rge};
            tx <= TOFF_W'(cge ? crem_sh - {1'b0, cfg.bw} : crem_sh);
            ty <= TOFF_W'(rge ? rrem_sh - {1'b0, cfg.bh} : rrem_sh);
          end
        end
        F_ACC: begin
          if (!tile_end || !job_full) begin
            if (wrap) valid <= '0;
            else      valid[addr] <= !tile_end;
          end
        end
        default: ;
      endcase
    end
  end

  // divider datapath for the recompute
  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      cnum <= col_pos;
      rnum <= row_pos;
      crem <= '0;
      rrem <= '0;
    end else if (state == F_RECALC) begin
      cnum <= {cnum[POS_W-2:0], cge};
      rnum <= {rnum[POS_W-2:0], rge};
      crem <= cge ? crem_sh - {1'b0, cfg.bw} : crem_sh;
      rrem <= rge ? rrem_sh - {1'b0, cfg.bh} : rrem_sh;
    end
  end

  // latch the accepted pixel
  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      pix      <= pixel;
      addr     <= tc_e[AW-1:0];
      tile_end <= tx_last && ty_last;
      rend     <= (tc_e == POS_W'(cfg.oc - DIM_W'(1)));
      fend     <= (tc_e == POS_W'(cfg.oc - DIM_W'(1)))
                  && (tr_e == POS_W'(cfg.orows - DIM_W'(1)));
      wrap     <= col_wrap && row_wrap;
    end
  end

endmodule

// ===== rtl/bda_back.sv =====
`timescale 1ns / 1ps
// Back part: divides a tile sum by the tile area, maps the average onto the
// ramp and holds the result for the receiver. Depends on bda_pkg.
module bda_back
  import bda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              job_empty,
  input  job_t              job,
  output logic              job_rd,
  output logic              empty,
  input  logic              pop,
  output logic [PIX_W-1:0]  average,
  output logic [CODE_W-1:0] char_code,
  output logic              row_end,
  output logic              frame_end
);

  localparam int CW = $clog2(SUM_W + 1);

  back_state_t state;
  back_state_t state_next;

  logic [SUM_W-1:0]  num;
  logic [AREA_W-1:0] dvsr;
  logic [AREA_W:0]   rem, rem_sh;
  logic              ge;
  logic [CW-1:0]     cnt;
  logic              last;
  logic              rend, fend, out_valid;
  logic [PIX_W-1:0]  avg, avg_q;
  logic [CODE_W-1:0] code;
  logic [15:0]       span_mul;
  logic [4:0]        step;
  logic [3:0]        idx_q;

  assign rem_sh = {rem[AREA_W-1:0], num[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvsr};
  assign last   = (cnt == CW'(SUM_W - 1));
  assign job_rd = (state == B_IDLE) && !job_empty;
  assign empty  = !out_valid;

  // quotient of the finished step, saturated
  assign avg_q = (|{num[SUM_W-2:PIX_W-1]}) ? PIX_MAX : {num[PIX_W-2:0], ge};
  assign idx_q = (|{num[SUM_W-2:3]} || ({num[2:0], ge} > RAMP_TOP))
                 ? RAMP_TOP : {num[2:0], ge};

  // ramp step width: (255 - thr) / 10, at least 1
  assign span_mul = 16'(PIX_MAX - cfg.thr) * 16'd205;
  assign step     = (span_mul[15:11] == 5'd0) ? 5'd1 : span_mul[15:11];

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!job_empty) state_next = B_DIV1;
      B_DIV1: begin
        if (last) state_next = (avg_q > cfg.thr) ? B_DIV2 : B_OUT;
      end
      B_DIV2: if (last) state_next = B_OUT;
      B_OUT:  if (!out_valid || pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  // shared restoring divider
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        num  <= job.sum;
        dvsr <= AREA_W'(cfg.bw) * AREA_W'(cfg.bh);
        rem  <= '0;
        cnt  <= '0;
        rend <= job.row_end;
        fend <= job.frame_end;
      end
      B_DIV1: begin
        if (last) begin
          avg  <= avg_q;
          code <= ramp_code(4'd0);
          num  <= SUM_W'(avg_q - cfg.thr);
          dvsr <= AREA_W'(step);
          rem  <= '0;
          cnt  <= '0;
        end else begin
          num <= {num[SUM_W-2:0], ge};
          rem <= ge ? rem_sh - {1'b0, dvsr} : rem_sh;
          cnt <= cnt + CW'(1);
        end
      end
      B_DIV2: begin
        if (last) begin
          code <= ramp_code(idx_q);
        end else begin
          num <= {num[SUM_W-2:0], ge};
          rem <= ge ? rem_sh - {1'b0, dvsr} : rem_sh;
          cnt <= cnt + CW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && (!out_valid || pop)) begin
      average   <= avg;
      char_code <= code;
      row_end   <= rend;
      frame_end <= fend;
    end
  end

endmodule

// ===== rtl/box_downscale_ascii_map.sv =====
`timescale 1ns / 1ps
// Block-average downscaler with ASCII ramp: top level with the register file.
// Depends on bda_pkg, bda_front, bda_fifo, bda_back.
//
// Pixels enter in raster order on push/full (transfer when push is high and
// full is low); start_frame clears positions and sums before its pixel.
// Tile results leave on empty/pop (transfer when pop is high and empty is
// low); the oldest result sits on average, char_code, row_end, frame_end.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// the user must write only while the block is idle; the block does not enforce it.
// Flow: a pixel outside the tiled area is not summed, while one inside is
// read and then its column sum in RAM is updated, with full high until the
// update is done. The back divider is shared by the area division and the
// ramp division, and the ramp division is skipped when the average is at or
// below the threshold; a two-entry queue lets the front go on meanwhile.
// A result passes from the queue through the area division, the ramp
// division (above the threshold only) and the output register. After a
// register write the front recomputes the tile position before it takes pixels.
// Reset restores default registers, clears positions and valid bits of the
// sums at once (no clearing pass). When the receiver stalls, results back up
// through the output register and queue, then full rises.
module box_downscale_ascii_map
  import bda_pkg::*;
#(
  parameter int MAX_OUT_COLS = DEF_OUT_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              start_frame,
  output logic              empty,
  input  logic              pop,
  output logic [PIX_W-1:0]  average,
  output logic [CODE_W-1:0] char_code,
  output logic              row_end,
  output logic              frame_end
);

  logic [SRC_W-1:0] src_width, src_height;
  logic [DIM_W-1:0] block_w, block_h, out_cols, out_rows;
  logic [THR_W-1:0] threshold;
  cfg_t             cfg;
  logic             job_wr, job_full, job_rd, job_empty;
  job_t             job_in, job_out;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_DIM;
      src_height <= RST_SRC_DIM;
      block_w    <= RST_BLOCK;
      block_h    <= RST_BLOCK;
      out_cols   <= RST_OUT_DIM;
      out_rows   <= RST_OUT_DIM;
      threshold  <= RST_THR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_BLOCK_W:    block_w    <= cfg_data[DIM_W-1:0];
        REG_BLOCK_H:    block_h    <= cfg_data[DIM_W-1:0];
        REG_OUT_COLS:   out_cols   <= cfg_data[DIM_W-1:0];
        REG_OUT_ROWS:   out_rows   <= cfg_data[DIM_W-1:0];
        REG_THRESHOLD:  threshold  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to legal ranges
  always_comb begin
    cfg.sw    = (src_width == '0) ? SRC_W'(1)
              : (src_width > SRC_W'(MAX_SRC_DIM)) ? SRC_W'(MAX_SRC_DIM) : src_width;
    cfg.sh    = (src_height == '0) ? SRC_W'(1)
              : (src_height > SRC_W'(MAX_SRC_DIM)) ? SRC_W'(MAX_SRC_DIM) : src_height;
    cfg.bw    = (block_w == '0) ? DIM_W'(1)
              : (block_w > DIM_W'(MAX_BLOCK_DIM)) ? DIM_W'(MAX_BLOCK_DIM) : block_w;
    cfg.bh    = (block_h == '0) ? DIM_W'(1)
              : (block_h > DIM_W'(MAX_BLOCK_DIM)) ? DIM_W'(MAX_BLOCK_DIM) : block_h;
    cfg.oc    = (out_cols == '0) ? DIM_W'(1)
              : (32'(out_cols) > MAX_OUT_COLS) ? DIM_W'(MAX_OUT_COLS) : out_cols;
    cfg.orows = (out_rows == '0) ? DIM_W'(1)
              : (32'(out_rows) > MAX_OUT_COLS) ? DIM_W'(MAX_OUT_COLS) : out_rows;
    cfg.thr   = threshold;
  end

  bda_front #(.MAX_OUT_COLS(MAX_OUT_COLS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_wr      (cfg_we),
    .push        (push),
    .full        (full),
    .pixel       (pixel),
    .start_frame (start_frame),
    .job_wr      (job_wr),
    .job         (job_in),
    .job_full    (job_full)
  );

  bda_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (job_wr),
    .wdata (job_in),
    .full  (job_full),
    .rd    (job_rd),
    .rdata (job_out),
    .empty (job_empty)
  );

  bda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_out),
    .job_rd    (job_rd),
    .empty     (empty),
    .pop       (pop),
    .average   (average),
    .char_code (char_code),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

endmodule
